@@ hdl/acn_pkg.sv @@
// Shared types and constants for the adjacency common-neighbor block.
// Holds the transaction payload structs, the operation and status codes and
// the parameter defaults. No dependencies.
package acn_pkg;

	localparam int ID_W             = 10;
	localparam int NUM_VERTICES_DEF = 1024;
	localparam int MAX_DEGREE_DEF   = 32;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_MATCH          = 3'd0,
		ST_NONE           = 3'd1,
		ST_FIRST_UNKNOWN  = 3'd2,
		ST_SECOND_UNKNOWN = 3'd3,
		ST_STORED         = 3'd4,
		ST_DROPPED        = 3'd5,
		ST_SAME           = 3'd6
	} status_t;

	typedef struct packed {
		op_t             operation;
		logic [ID_W-1:0] first_id;
		logic [ID_W-1:0] second_id;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] neighbor_id;
		logic            last;
	} rsp_t;

endpackage

@@ hdl/acn_seq.sv @@
// Sequencer of the common-neighbor block: degree and neighbor memories,
// the shared id comparator and the per-transaction control.
// Depends on acn_pkg.
module acn_seq #(
	parameter int NUM_VERTICES = acn_pkg::NUM_VERTICES_DEF,
	parameter int MAX_DEGREE   = acn_pkg::MAX_DEGREE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  acn_pkg::req_t req,
	input  logic         push_free,
	output logic         push,
	output acn_pkg::rsp_t push_item
);
	import acn_pkg::*;

	localparam int VW       = $clog2(NUM_VERTICES);
	localparam int SW       = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DW       = $clog2(MAX_DEGREE + 1);
	localparam int NB_DEPTH = NUM_VERTICES << SW;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_ADD    = 11'b000_0000_0100,
		S_QDEGA  = 11'b000_0000_1000,
		S_QDEGB  = 11'b000_0001_0000,
		S_LOADA  = 11'b000_0010_0000,
		S_GETA   = 11'b000_0100_0000,
		S_SCAN   = 11'b000_1000_0000,
		S_MATCH  = 11'b001_0000_0000,
		S_FINISH = 11'b010_0000_0000,
		S_RESULT = 11'b100_0000_0000
	} state_t;

	state_t          state_q, state_d;
	logic [VW-1:0]   clr_q;
	logic [ID_W-1:0] a_q, a_d, b_q, b_d;
	logic [DW-1:0]   deg_a_q, deg_a_d, deg_b_q, deg_b_d;
	logic [DW-1:0]   i_q, i_d, j_q, j_d, i_next;
	logic [ID_W-1:0] val_q, val_d;
	logic            pend_valid_q, pend_valid_d;
	logic [ID_W-1:0] pend_id_q, pend_id_d;
	status_t         res_status_q, res_status_d;

	logic [DW-1:0]   deg_mem [NUM_VERTICES];
	logic [ID_W-1:0] nb_mem  [NB_DEPTH];
	logic [DW-1:0]   deg_rd_q;
	logic [ID_W-1:0] nb_rd_q;

	logic [VW-1:0]    deg_rd_addr, deg_wr_addr;
	logic             deg_we;
	logic [DW-1:0]    deg_wr_data;
	logic [VW+SW-1:0] nb_rd_addr, nb_wr_addr;
	logic             nb_we;

	logic a_in_range, b_in_range, deg_full, hit, scan_end, a_done;

	assign req_stall  = (state_q != S_IDLE);
	assign a_in_range = 32'(req.first_id) < NUM_VERTICES;
	assign b_in_range = 32'(b_q) < NUM_VERTICES;
	assign deg_full   = 32'(deg_rd_q) >= MAX_DEGREE;
	assign hit        = (nb_rd_q == val_q);
	assign scan_end   = (j_q == deg_b_q);
	assign i_next     = i_q + DW'(1);
	assign a_done     = (i_next == deg_a_q);

	// Simple dual-port storage: one read and one write address per memory.
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wr_addr] <= deg_wr_data;
		end
		deg_rd_q <= deg_mem[deg_rd_addr];
		if (nb_we) begin
			nb_mem[nb_wr_addr] <= b_q;
		end
		nb_rd_q <= nb_mem[nb_rd_addr];
	end

	always_comb begin
		state_d      = state_q;
		a_d          = a_q;
		b_d          = b_q;
		deg_a_d      = deg_a_q;
		deg_b_d      = deg_b_q;
		i_d          = i_q;
		j_d          = j_q;
		val_d        = val_q;
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		res_status_d = res_status_q;

		deg_rd_addr = VW'(a_q);
		deg_we      = 1'b0;
		deg_wr_addr = VW'(a_q);
		deg_wr_data = deg_rd_q + DW'(1);
		nb_rd_addr  = {VW'(a_q), SW'(i_q)};
		nb_we       = 1'b0;
		nb_wr_addr  = {VW'(a_q), SW'(deg_rd_q)};

		push                  = 1'b0;
		push_item.status      = ST_NONE;
		push_item.neighbor_id = '0;
		push_item.last        = 1'b1;

		case (state_q)
			S_CLEAR: begin
				deg_we      = 1'b1;
				deg_wr_addr = clr_q;
				deg_wr_data = '0;
				if (clr_q == VW'(NUM_VERTICES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// Look up the first vertex's degree while the transaction lands.
				deg_rd_addr = VW'(req.first_id);
				if (req_valid) begin
					a_d = req.first_id;
					b_d = req.second_id;
					if (req.operation == OP_ADD) begin
						if (a_in_range) begin
							state_d = S_ADD;
						end else begin
							res_status_d = ST_DROPPED;
							state_d      = S_RESULT;
						end
					end else if (req.first_id == req.second_id) begin
						res_status_d = ST_SAME;
						state_d      = S_RESULT;
					end else if (!a_in_range) begin
						res_status_d = ST_FIRST_UNKNOWN;
						state_d      = S_RESULT;
					end else begin
						state_d = S_QDEGA;
					end
				end
			end
			S_ADD: begin
				state_d = S_RESULT;
				if (deg_full) begin
					res_status_d = ST_DROPPED;
				end else begin
					deg_we       = 1'b1;
					nb_we        = 1'b1;
					res_status_d = ST_STORED;
				end
			end
			S_QDEGA: begin
				deg_rd_addr = VW'(b_q);
				deg_a_d     = deg_rd_q;
				if (deg_rd_q == '0) begin
					res_status_d = ST_FIRST_UNKNOWN;
					state_d      = S_RESULT;
				end else if (!b_in_range) begin
					res_status_d = ST_SECOND_UNKNOWN;
					state_d      = S_RESULT;
				end else begin
					state_d = S_QDEGB;
				end
			end
			S_QDEGB: begin
				deg_b_d = deg_rd_q;
				i_d     = '0;
				if (deg_rd_q == '0) begin
					res_status_d = ST_SECOND_UNKNOWN;
					state_d      = S_RESULT;
				end else begin
					state_d = S_LOADA;
				end
			end
			S_LOADA: begin
				state_d = S_GETA;
			end
			S_GETA: begin
				val_d      = nb_rd_q;
				nb_rd_addr = {VW'(b_q), SW'(0)};
				j_d        = DW'(1);
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				// Compare the entry read last cycle, fetch the next one.
				nb_rd_addr = {VW'(b_q), SW'(j_q)};
				if (hit) begin
					state_d = S_MATCH;
				end else if (scan_end) begin
					i_d     = i_next;
					state_d = a_done ? S_FINISH : S_LOADA;
				end else begin
					j_d = j_q + DW'(1);
				end
			end
			S_MATCH: begin
				// Hold each match back one step so the final one can carry last.
				if (pend_valid_q) begin
					push                  = push_free;
					push_item.status      = ST_MATCH;
					push_item.neighbor_id = pend_id_q;
					push_item.last        = 1'b0;
				end
				if (!pend_valid_q || push_free) begin
					pend_valid_d = 1'b1;
					pend_id_d    = val_q;
					i_d          = i_next;
					state_d      = a_done ? S_FINISH : S_LOADA;
				end
			end
			S_FINISH: begin
				if (push_free) begin
					push = 1'b1;
					if (pend_valid_q) begin
						push_item.status      = ST_MATCH;
						push_item.neighbor_id = pend_id_q;
					end
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			S_RESULT: begin
				if (push_free) begin
					push             = 1'b1;
					push_item.status = res_status_q;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + VW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q          <= a_d;
		b_q          <= b_d;
		deg_a_q      <= deg_a_d;
		deg_b_q      <= deg_b_d;
		i_q          <= i_d;
		j_q          <= j_d;
		val_q        <= val_d;
		pend_id_q    <= pend_id_d;
		res_status_q <= res_status_d;
	end

endmodule

@@ hdl/acn_out.sv @@
// Output register of the common-neighbor block: holds one result
// transaction until the receiver takes it. Depends on acn_pkg.
module acn_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  acn_pkg::rsp_t push_item,
	output logic          push_free,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output acn_pkg::rsp_t rsp
);
	import acn_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign push_free = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_item;
		end
	end

endmodule

@@ hdl/adjacency_common_neighbors.sv @@
// Adjacency store with common-neighbor query.
// Request channel (req_valid/req_stall/req): an add-edge transaction appends
// second_id to first_id's neighbor list; a query transaction lists every entry
// of first_id's list that also occurs in second_id's list, in list order.
// Response channel (rsp_valid/rsp_stall/rsp): one result per add, rejected
// or matchless query, one per match otherwise; last marks the final result.
// One transaction is in flight at a time; req_stall is high until its final
// result has been handed to the output register.
// Flow: an in-range add passes through S_ADD to S_RESULT, and a query rejected
// on its ids goes to S_RESULT from S_IDLE, S_QDEGA or S_QDEGB. A query compares
// one stored id per cycle through the single read port of the neighbor memory:
// each entry of first_id's list is fetched in S_LOADA and S_GETA and compared
// against second_id's list in S_SCAN, and a match is handed on from S_MATCH,
// where the sequencer waits while the output register is not free. After the
// last entry, S_FINISH hands the final result on and req_stall falls.
// Reset: the degree memory is cleared after reset by a pass over all
// NUM_VERTICES entries (1024 by default), with req_stall high meanwhile.
// A stalled receiver holds the output register; the sequencer waits on it.
// Depends on acn_pkg, acn_seq and acn_out.
module adjacency_common_neighbors #(
	parameter int NUM_VERTICES = acn_pkg::NUM_VERTICES_DEF,
	parameter int MAX_DEGREE   = acn_pkg::MAX_DEGREE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  acn_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output acn_pkg::rsp_t rsp
);
	import acn_pkg::*;

	logic push, push_free;
	rsp_t push_item;

	acn_seq #(
		.NUM_VERTICES (NUM_VERTICES),
		.MAX_DEGREE   (MAX_DEGREE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push_free (push_free),
		.push      (push),
		.push_item (push_item)
	);

	acn_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_free (push_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for adjacency_common_neighbors: directed table, then random traffic.
// Results are checked in order against a behavioral mirror of the lists or a table row's status.
// Depends on acn_pkg and the block's RTL.
module tb;
	import acn_pkg::*;

	localparam int NUM_V      = NUM_VERTICES_DEF;
	localparam int MAX_DEG    = MAX_DEGREE_DEF;
	localparam int DEG_W      = $clog2(MAX_DEG + 1);
	localparam int RAND_ITEMS = 420;
	localparam int HOLD_CYC   = 400;
	localparam int POOL_V     = 12;
	localparam int POOL_N     = 16;
	localparam int N_PLAN     = 21;

	typedef struct {
		op_t             op;
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		int              reps;
		bit              typed;
		status_t         st;
	} row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// mirror of the adjacency store
	logic [DEG_W-1:0] mirror_degree [NUM_V];
	logic [ID_W-1:0]  mirror_list   [NUM_V][MAX_DEG];

	rsp_t fresh_rsp   [$];
	rsp_t awaited_rsp [$];

	int  err_count   = 0;
	int  n_items     = 0;
	int  n_rsp       = 0;
	int  n_common    = 0;
	int  n_dropped   = 0;
	bit  quiet       = 1'b0;
	bit  hold_req    = 1'b0;
	int  hold_left   = 0;
	int  rsp_gap     = 0;

	logic [ID_W-1:0] vpool [POOL_V];
	logic [ID_W-1:0] npool [POOL_N];

	// op, first, second, repeat (second advances per repeat), typed, status
	row_t plan [N_PLAN] = '{
		'{OP_QUERY, 10'd0,    10'd1,    1,  1'b1, ST_FIRST_UNKNOWN},
		'{OP_QUERY, 10'd5,    10'd5,    1,  1'b1, ST_SAME},
		'{OP_QUERY, 10'd1023, 10'd1023, 1,  1'b1, ST_SAME},
		'{OP_ADD,   10'd1023, 10'd0,    1,  1'b1, ST_STORED},
		'{OP_ADD,   10'd0,    10'd1023, 1,  1'b1, ST_STORED},
		'{OP_QUERY, 10'd1023, 10'd0,    1,  1'b0, ST_NONE},
		'{OP_ADD,   10'd0,    10'd0,    1,  1'b1, ST_STORED},
		'{OP_QUERY, 10'd1023, 10'd0,    1,  1'b0, ST_NONE},
		'{OP_QUERY, 10'd0,    10'd1023, 1,  1'b0, ST_NONE},
		'{OP_QUERY, 10'd0,    10'd7,    1,  1'b1, ST_SECOND_UNKNOWN},
		'{OP_QUERY, 10'd7,    10'd0,    1,  1'b1, ST_FIRST_UNKNOWN},
		'{OP_ADD,   10'd0,    10'd0,    1,  1'b1, ST_STORED},
		'{OP_QUERY, 10'd0,    10'd1023, 1,  1'b0, ST_NONE},
		'{OP_ADD,   10'd2,    10'd100,  32, 1'b1, ST_STORED},
		'{OP_ADD,   10'd2,    10'd555,  1,  1'b1, ST_DROPPED},
		'{OP_ADD,   10'd3,    10'd100,  32, 1'b1, ST_STORED},
		'{OP_QUERY, 10'd2,    10'd3,    1,  1'b0, ST_NONE},
		'{OP_QUERY, 10'd3,    10'd2,    1,  1'b0, ST_NONE},
		'{OP_QUERY, 10'd2,    10'd0,    1,  1'b0, ST_NONE},
		'{OP_ADD,   10'd1023, 10'd1023, 1,  1'b1, ST_STORED},
		'{OP_QUERY, 10'd1023, 10'd2,    1,  1'b0, ST_NONE}
	};

	adjacency_common_neighbors DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t mk_rsp(status_t st, logic [ID_W-1:0] id, logic lst);
		rsp_t r;
		r.status      = st;
		r.neighbor_id = id;
		r.last        = lst;
		return r;
	endfunction

	// Append one predicted result to fresh_rsp.
	function automatic void add_fresh(rsp_t r);
		fresh_rsp = {fresh_rsp, r};
	endfunction

	// Update the mirror with one request and leave its results in fresh_rsp.
	function automatic void apply_to_adjacency(req_t item);
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		logic [ID_W-1:0] v;
		bit hit;
		a = item.first_id;
		b = item.second_id;
		fresh_rsp.delete();
		if (item.operation == OP_ADD) begin
			if (int'(a) >= NUM_V || int'(mirror_degree[a]) >= MAX_DEG) begin
				add_fresh(mk_rsp(ST_DROPPED, '0, 1'b1));
			end else begin
				mirror_list[a][mirror_degree[a]] = b;
				mirror_degree[a] = mirror_degree[a] + 1'b1;
				add_fresh(mk_rsp(ST_STORED, '0, 1'b1));
			end
		end else if (a == b) begin
			add_fresh(mk_rsp(ST_SAME, '0, 1'b1));
		end else if (int'(a) >= NUM_V || mirror_degree[a] == 0) begin
			add_fresh(mk_rsp(ST_FIRST_UNKNOWN, '0, 1'b1));
		end else if (int'(b) >= NUM_V || mirror_degree[b] == 0) begin
			add_fresh(mk_rsp(ST_SECOND_UNKNOWN, '0, 1'b1));
		end else begin
			for (int i = 0; i < int'(mirror_degree[a]); i++) begin
				v = mirror_list[a][i];
				hit = 1'b0;
				for (int j = 0; j < int'(mirror_degree[b]); j++)
					if (mirror_list[b][j] == v)
						hit = 1'b1;
				if (hit)
					add_fresh(mk_rsp(ST_MATCH, v, 1'b0));
			end
			if (fresh_rsp.size() == 0)
				add_fresh(mk_rsp(ST_NONE, '0, 1'b1));
			else
				fresh_rsp[fresh_rsp.size()-1].last = 1'b1;
		end
	endfunction

	task automatic flag(string what);
		err_count++;
		$display("tb: mismatch: %s", what);
	endtask

	// Offer one transaction, optionally after an idle burst; return at its acceptance edge.
	task automatic offer(req_t item, bit typed, status_t st);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		n_items++;
		apply_to_adjacency(item);
		if (typed)
			awaited_rsp = {awaited_rsp, mk_rsp(st, '0, 1'b1)};
		else
			awaited_rsp = {awaited_rsp, fresh_rsp};
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			rsp_gap = $urandom_range(0, 6);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rsp++;
			if (awaited_rsp.size() == 0) begin
				flag($sformatf("unexpected result status=%0d id=%0d last=%0b",
					rsp.status, rsp.neighbor_id, rsp.last));
			end else begin
				exp_r = awaited_rsp.pop_front();
				if (rsp.status !== exp_r.status)
					flag($sformatf("result %0d status %0d, want %0d",
						n_rsp, rsp.status, exp_r.status));
				if (rsp.neighbor_id !== exp_r.neighbor_id)
					flag($sformatf("result %0d neighbor_id %0d, want %0d",
						n_rsp, rsp.neighbor_id, exp_r.neighbor_id));
				if (rsp.last !== exp_r.last)
					flag($sformatf("result %0d last %0b, want %0b",
						n_rsp, rsp.last, exp_r.last));
				if (exp_r.status == ST_MATCH)
					n_common++;
				if (exp_r.status == ST_DROPPED)
					n_dropped++;
			end
		end
	end

	initial begin
		req_t item;
		for (int i = 0; i < NUM_V; i++)
			mirror_degree[i] = '0;
		for (int i = 0; i < NUM_V; i++)
			for (int j = 0; j < MAX_DEG; j++)
				mirror_list[i][j] = '0;
		foreach (vpool[i])
			vpool[i] = ID_W'($urandom_range(0, NUM_V - 1));
		foreach (npool[i])
			npool[i] = ID_W'($urandom_range(0, NUM_V - 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r])
			for (int k = 0; k < plan[r].reps; k++) begin
				item.operation = plan[r].op;
				item.first_id  = plan[r].a;
				item.second_id = plan[r].b + k[ID_W-1:0];
				offer(item, plan[r].typed, plan[r].st);
			end

		// let the directed part drain before random traffic
		wait_drained();

		for (int k = 0; k < RAND_ITEMS; k++) begin
			if (k == 150)
				hold_req = 1'b1;
			if (k == 300)
				wait_drained();
			quiet = (k >= RAND_ITEMS - 60);
			item.operation = op_t'($urandom_range(0, 1));
			if ($urandom_range(0, 9) < 8) begin
				item.first_id = vpool[$urandom_range(0, POOL_V - 1)];
				if (item.operation == OP_ADD)
					item.second_id = npool[$urandom_range(0, POOL_N - 1)];
				else
					item.second_id = vpool[$urandom_range(0, POOL_V - 1)];
			end else begin
				item.first_id  = ID_W'($urandom_range(0, NUM_V - 1));
				item.second_id = ID_W'($urandom_range(0, NUM_V - 1));
			end
			offer(item, 1'b0, ST_NONE);
		end

		wait_drained();
		repeat (64) @(posedge clk);

		$display("tb: %0d requests, %0d results, %0d common neighbors, %0d dropped adds",
			n_items, n_rsp, n_common, n_dropped);
		$display("tb: covered empty, full and duplicate lists, self loops, a long output hold");
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: timeout");
		$display("tb: done, errors");
		$finish;
	end

endmodule
